FILE: hdl/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg
// Shared codes, widths, result types and the combinational integer ALU.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int DATA_W          = 32;
  localparam int IDX_W           = 10;
  localparam int CNT_W           = 11;
  localparam int ENTRY_W         = DATA_W + 1;   // known flag on top of the value
  localparam int VALUE_SLOTS_DEF = 1024;

  // instruction modes
  localparam logic [2:0] MODE_CONST = 3'd0;
  localparam logic [2:0] MODE_INT   = 3'd1;
  localparam logic [2:0] MODE_CAST  = 3'd2;
  localparam logic [2:0] MODE_FLOAT = 3'd3;
  localparam logic [2:0] MODE_PADD  = 3'd4;
  localparam logic [2:0] MODE_PDIFF = 3'd5;
  localparam logic [2:0] MODE_KILL  = 3'd6;
  localparam logic [2:0] MODE_PASS  = 3'd7;

  // integer op codes
  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_SUB  = 5'd1;
  localparam logic [4:0] OP_MUL  = 5'd2;
  localparam logic [4:0] OP_DIV  = 5'd3;
  localparam logic [4:0] OP_MOD  = 5'd4;
  localparam logic [4:0] OP_SHL  = 5'd5;
  localparam logic [4:0] OP_SHR  = 5'd6;
  localparam logic [4:0] OP_AND  = 5'd7;
  localparam logic [4:0] OP_OR   = 5'd8;
  localparam logic [4:0] OP_XOR  = 5'd9;
  localparam logic [4:0] OP_EQ   = 5'd10;
  localparam logic [4:0] OP_NE   = 5'd11;
  localparam logic [4:0] OP_LT   = 5'd12;
  localparam logic [4:0] OP_GT   = 5'd13;
  localparam logic [4:0] OP_LE   = 5'd14;
  localparam logic [4:0] OP_GE   = 5'd15;
  localparam logic [4:0] OP_LAND = 5'd16;
  localparam logic [4:0] OP_LOR  = 5'd17;

  // float op codes
  localparam logic [1:0] FOP_ADD = 2'd0;
  localparam logic [1:0] FOP_SUB = 2'd1;
  localparam logic [1:0] FOP_MUL = 2'd2;
  localparam logic [1:0] FOP_DIV = 2'd3;
  localparam logic [4:0] FOP_MAX = 5'd3;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [30:0] F_INF     = 31'h7F80_0000;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } unit_rsp_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

  // combinational integer ops; mul, div and mod are done outside this function
  function automatic logic [DATA_W-1:0] int_alu(input logic [4:0] op,
                                                 input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic lt;
    logic gt;
    logic [DATA_W-1:0] r;
    lt = $signed(a) < $signed(b);
    gt = $signed(b) < $signed(a);
    case (op)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_SHL:  r = a << b[4:0];
      OP_SHR:  r = $unsigned($signed(a) >>> b[4:0]);
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      OP_EQ:   r = {31'd0, a == b};
      OP_NE:   r = {31'd0, a != b};
      OP_LT:   r = {31'd0, lt};
      OP_GT:   r = {31'd0, gt};
      OP_LE:   r = {31'd0, !gt};
      OP_GE:   r = {31'd0, !lt};
      OP_LAND: r = {31'd0, (a != '0) && (b != '0)};
      OP_LOR:  r = {31'd0, (a != '0) || (b != '0)};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/cft_store.sv
// ----------------------------------------------------------------------------
// cft_store
// Value table: known flag and 32-bit value per value number, one write port,
// two registered read ports.
// ----------------------------------------------------------------------------
module cft_store import cft_pkg::*; #(
  parameter int DEPTH = VALUE_SLOTS_DEF,
  parameter int AW    = $clog2(VALUE_SLOTS_DEF)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr1,
  input  logic [AW-1:0]      raddr2,
  output logic [ENTRY_W-1:0] rdata1,
  output logic [ENTRY_W-1:0] rdata2
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd1_r;
  logic [ENTRY_W-1:0] rd2_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd1_r <= mem[raddr1];
      rd2_r <= mem[raddr2];
    end
  end

  assign rdata1 = rd1_r;
  assign rdata2 = rd2_r;

endmodule

FILE: hdl/cft_idiv.sv
// ----------------------------------------------------------------------------
// cft_idiv
// Signed 32-bit divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cft_idiv import cft_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_rsp_t          rsp
);

  typedef enum logic [1:0] {
    D_IDLE = 2'b01,
    D_RUN  = 2'b10
  } dstate_t;

  dstate_t           st_r;
  logic [DATA_W-1:0] n_r;
  logic [DATA_W-1:0] d_r;
  logic [DATA_W-1:0] rem_r;
  logic [4:0]        cnt_r;
  logic              neg_q_r;
  logic              neg_r_r;
  logic              done_r;
  logic [DATA_W-1:0] quot_r;
  logic [DATA_W-1:0] remo_r;

  logic [DATA_W:0]   trial;
  logic              ge;
  logic [DATA_W-1:0] rem_nxt;
  logic [DATA_W-1:0] q_fin;

  always_comb begin
    trial   = {rem_r, n_r[DATA_W-1]};
    ge      = trial >= {1'b0, d_r};
    rem_nxt = ge ? DATA_W'(trial - {1'b0, d_r}) : trial[DATA_W-1:0];
    q_fin   = {n_r[DATA_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (start) begin
            if (divisor == '0) begin
              quot_r <= '0;
              remo_r <= '0;
              done_r <= 1'b1;
            end else begin
              n_r     <= dividend[DATA_W-1] ? -dividend : dividend;
              d_r     <= divisor[DATA_W-1] ? -divisor : divisor;
              neg_q_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
              neg_r_r <= dividend[DATA_W-1];
              rem_r   <= '0;
              cnt_r   <= '0;
              st_r    <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_r <= rem_nxt;
          n_r   <= q_fin;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            quot_r <= neg_q_r ? -q_fin : q_fin;
            remo_r <= neg_r_r ? -rem_nxt : rem_nxt;
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.quot  = quot_r;
  assign rsp.rem   = remo_r;

endmodule

FILE: hdl/cft_fpu.sv
// ----------------------------------------------------------------------------
// cft_fpu
// binary32 add/sub/mul/div, round to nearest even; sequenced unpack,
// iterative mantissa divide, bit-per-cycle normalise, then round.
// ----------------------------------------------------------------------------
module cft_fpu import cft_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        op,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output unit_rsp_t         rsp
);

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_SETUP = 6'b000010,
    F_PNORM = 6'b000100,
    F_DIV   = 6'b001000,
    F_NORM  = 6'b010000,
    F_ROUND = 6'b100000
  } fstate_t;

  fstate_t            st_r;
  logic [1:0]         op_r;
  logic [31:0]        a_r;
  logic [31:0]        b_r;
  logic               sgn_r;
  logic signed [11:0] exp_r;
  logic [50:0]        wm_r;     // leading one lands on bit 49
  logic               stk_r;
  logic [23:0]        ma_r;
  logic [23:0]        mb_r;
  logic signed [11:0] ea_r;
  logic signed [11:0] eb_r;
  logic [25:0]        rem_r;
  logic [25:0]        q_r;
  logic [4:0]         cnt_r;
  logic [31:0]        res_r;
  logic               done_r;

  // unpack
  logic               a_zero, a_inf, a_nan, b_zero, b_inf, b_nan;
  logic [23:0]        ma, mb;
  logic signed [11:0] a_e, b_e;
  logic               sbe, sx;
  logic               spec;
  logic [31:0]        spec_val;
  // add path
  logic               a_ge;
  logic [23:0]        m_big, m_small;
  logic signed [11:0] e_big;
  logic [7:0]         e_sml, shamt;
  logic               s_big, s_sml;
  logic [50:0]        x_op, y_full, y_sh, add_wm;
  logic               lost;
  // mul path
  logic [47:0]        prod;
  // div step
  logic               dge;
  logic [25:0]        ddiff;
  // rounding
  logic [23:0]        sig;
  logic               rinc;
  logic [24:0]        sum25;
  logic [23:0]        rsig;
  logic signed [11:0] rexp;

  always_comb begin
    a_zero = a_r[30:0] == '0;
    b_zero = b_r[30:0] == '0;
    a_inf  = (a_r[30:23] == 8'hFF) && (a_r[22:0] == '0);
    b_inf  = (b_r[30:23] == 8'hFF) && (b_r[22:0] == '0);
    a_nan  = (a_r[30:23] == 8'hFF) && (a_r[22:0] != '0);
    b_nan  = (b_r[30:23] == 8'hFF) && (b_r[22:0] != '0);
    ma     = {a_r[30:23] != '0, a_r[22:0]};
    mb     = {b_r[30:23] != '0, b_r[22:0]};
    a_e    = {4'd0, (a_r[30:23] == '0) ? 8'd1 : a_r[30:23]};
    b_e    = {4'd0, (b_r[30:23] == '0) ? 8'd1 : b_r[30:23]};
    sbe    = b_r[31] ^ (op_r == FOP_SUB);
    sx     = a_r[31] ^ b_r[31];

    spec     = 1'b0;
    spec_val = '0;
    case (op_r)
      FOP_ADD, FOP_SUB: begin
        if (a_nan || b_nan) begin
          spec = 1'b1; spec_val = CANON_NAN;
        end else if (a_inf && b_inf) begin
          spec = 1'b1; spec_val = (a_r[31] == sbe) ? {a_r[31], F_INF} : CANON_NAN;
        end else if (a_inf) begin
          spec = 1'b1; spec_val = {a_r[31], F_INF};
        end else if (b_inf) begin
          spec = 1'b1; spec_val = {sbe, F_INF};
        end
      end
      FOP_MUL: begin
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
          spec = 1'b1; spec_val = CANON_NAN;
        end else if (a_inf || b_inf) begin
          spec = 1'b1; spec_val = {sx, F_INF};
        end
      end
      default: begin
        // zero divisor gives +0 whatever the dividend
        if (b_zero) begin
          spec = 1'b1; spec_val = '0;
        end else if (a_nan || b_nan || (a_inf && b_inf)) begin
          spec = 1'b1; spec_val = CANON_NAN;
        end else if (a_inf) begin
          spec = 1'b1; spec_val = {sx, F_INF};
        end else if (b_inf || a_zero) begin
          spec = 1'b1; spec_val = {sx, 31'd0};
        end
      end
    endcase

    a_ge    = a_r[30:0] >= b_r[30:0];
    m_big   = a_ge ? ma : mb;
    m_small = a_ge ? mb : ma;
    e_big   = a_ge ? a_e : b_e;
    e_sml   = a_ge ? b_e[7:0] : a_e[7:0];
    s_big   = a_ge ? a_r[31] : sbe;
    s_sml   = a_ge ? sbe : a_r[31];
    shamt   = e_big[7:0] - e_sml;
    x_op    = {1'b0, m_big, 26'd0};
    y_full  = {1'b0, m_small, 26'd0};
    y_sh    = y_full >> shamt;
    lost    = |(y_full & ~({51{1'b1}} << shamt));
    // sticky folded into the lsb, well below guard
    add_wm  = (s_big ^ s_sml) ? (x_op - (y_sh | {50'd0, lost}))
                              : (x_op + (y_sh | {50'd0, lost}));

    prod    = ma * mb;

    dge     = rem_r >= {2'd0, mb_r};
    ddiff   = dge ? (rem_r - {2'd0, mb_r}) : rem_r;

    sig     = wm_r[49:26];
    rinc    = wm_r[25] & ((|wm_r[24:0]) | stk_r | sig[0]);
    sum25   = {1'b0, sig} + {24'd0, rinc};
    rsig    = sum25[24] ? sum25[24:1] : sum25[23:0];
    rexp    = sum25[24] ? (exp_r + 12'sd1) : exp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        F_IDLE: begin
          if (start) begin
            a_r  <= a;
            b_r  <= b;
            op_r <= op;
            st_r <= F_SETUP;
          end
        end
        F_SETUP: begin
          if (spec) begin
            res_r  <= spec_val;
            done_r <= 1'b1;
            st_r   <= F_IDLE;
          end else begin
            case (op_r)
              FOP_ADD, FOP_SUB: begin
                if (add_wm == '0) begin
                  // exact zero: negative only when both addends are
                  res_r  <= {a_r[31] & sbe, 31'd0};
                  done_r <= 1'b1;
                  st_r   <= F_IDLE;
                end else begin
                  wm_r  <= add_wm;
                  exp_r <= e_big;
                  sgn_r <= s_big;
                  stk_r <= 1'b0;
                  st_r  <= F_NORM;
                end
              end
              FOP_MUL: begin
                wm_r  <= {1'b0, prod, 2'd0};
                exp_r <= a_e + b_e - 12'sd126;
                sgn_r <= sx;
                stk_r <= 1'b0;
                st_r  <= F_NORM;
              end
              default: begin
                ma_r  <= ma;
                mb_r  <= mb;
                ea_r  <= a_e;
                eb_r  <= b_e;
                sgn_r <= sx;
                st_r  <= F_PNORM;
              end
            endcase
          end
        end
        F_PNORM: begin
          // bring subnormal mantissas up to a leading one
          if (!ma_r[23]) begin
            ma_r <= {ma_r[22:0], 1'b0};
            ea_r <= ea_r - 12'sd1;
          end else if (!mb_r[23]) begin
            mb_r <= {mb_r[22:0], 1'b0};
            eb_r <= eb_r - 12'sd1;
          end else begin
            rem_r <= {2'd0, ma_r};
            q_r   <= '0;
            cnt_r <= '0;
            exp_r <= ea_r - eb_r + 12'sd127;
            st_r  <= F_DIV;
          end
        end
        F_DIV: begin
          q_r   <= {q_r[24:0], dge};
          rem_r <= {ddiff[24:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd26) begin
            wm_r  <= {1'b0, q_r, dge, 23'd0};
            stk_r <= ddiff != '0;
            st_r  <= F_NORM;
          end
        end
        F_NORM: begin
          if (wm_r[50]) begin
            wm_r  <= wm_r >> 1;
            stk_r <= stk_r | wm_r[0];
            exp_r <= exp_r + 12'sd1;
          end else if (exp_r < 12'sd1) begin
            if (wm_r == '0) begin
              exp_r <= 12'sd1;
            end else begin
              wm_r  <= wm_r >> 1;
              stk_r <= stk_r | wm_r[0];
              exp_r <= exp_r + 12'sd1;
            end
          end else if (!wm_r[49] && (wm_r != '0) && (exp_r > 12'sd1)) begin
            wm_r  <= wm_r << 1;
            exp_r <= exp_r - 12'sd1;
          end else begin
            st_r <= F_ROUND;
          end
        end
        F_ROUND: begin
          if ((rsig != '0) && (rexp >= 12'sd255)) begin
            res_r <= {sgn_r, F_INF};
          end else begin
            res_r <= {sgn_r, rsig[23] ? rexp[7:0] : 8'd0, rsig[22:0]};
          end
          done_r <= 1'b1;
          st_r   <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

FILE: hdl/constant_fold_tracker.sv
// ----------------------------------------------------------------------------
// constant_fold_tracker
// Constant propagation over a value-numbered instruction stream.
// ----------------------------------------------------------------------------
// One instruction at a time; every instruction yields exactly one result
// transaction. An instruction is accepted, both source entries are read from
// the value table, the result is worked out and the destination entry is
// written back while the result enters the output register, so the next
// read never overlaps a pending write. Const, cast, kill, pass, unknown
// sources and the combinational integer ops go straight from execute to
// write-back; integer multiply and pointer add pass a registered multiplier;
// integer divide/modulo and pointer difference wait on the bit-serial
// divider, which skips its iteration when the divisor is zero. Float special
// operands and exact zero sums finish at setup; float add/sub take longer
// the larger the normalising shift; float multiply and divide take longest
// for results that fall into the subnormal range, where the normaliser
// shifts right one bit at a time towards the least exponent (divide adds
// mantissa pre-normalise and a 27-step divide).
// Writing value_count starts a clearing pass over the first min(value_count,
// VALUE_SLOTS) table entries during which no instruction is taken. Result
// tuser is the folded flag; tdata is the constant, zero when not folded.
// ----------------------------------------------------------------------------
module constant_fold_tracker import cft_pkg::*; #(
  parameter int VALUE_SLOTS = VALUE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // instruction stream
  input  logic              in_tvalid,
  output logic              in_tready,
  // [0] dest_valid, [10:1] dest_index, [20:11] src1_index, [30:21] src2_index,
  // [62:31] immediate, [63] zero
  input  logic [63:0]       in_tdata,
  // [2:0] mode, [7:3] op
  input  logic [7:0]        in_tuser,
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  // [31:0] folded_value
  output logic [DATA_W-1:0] out_tdata,
  // [0] folded
  output logic              out_tuser,
  // value_count register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data
);

  localparam int AW = $clog2(VALUE_SLOTS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_EXEC  = 6'b000100,
    S_MUL   = 6'b001000,
    S_WAIT  = 6'b010000,
    S_WB    = 6'b100000
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  limit_r;     // min(value_count, VALUE_SLOTS)
  logic [CNT_W-1:0]  clr_r;

  // latched instruction
  logic [2:0]        mode_r;
  logic [4:0]        op_r;
  logic              dv_r;
  logic [IDX_W-1:0]  dst_r;
  logic [IDX_W-1:0]  s1_r;
  logic [IDX_W-1:0]  s2_r;
  logic [DATA_W-1:0] imm_r;

  logic              fold_r;
  logic              touch_r;
  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] prod_r;
  logic              wait_fp_r;
  logic              want_rem_r;

  logic              out_tvalid_r;
  logic [DATA_W-1:0] out_tdata_r;
  logic              out_tuser_r;

  logic              in_acc;
  logic              cfg_acc;
  logic              out_free;
  logic [CNT_W-1:0]  new_limit;

  logic [ENTRY_W-1:0] rd1, rd2;
  logic [DATA_W-1:0]  opa, opb;
  logic               known1, known2, both;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic               div_start;
  logic [DATA_W-1:0]  div_num;
  logic [DATA_W-1:0]  div_den;
  div_rsp_t           div_rsp;
  logic               fpu_start;
  unit_rsp_t          fpu_rsp;

  // handshakes; a config write takes precedence over an instruction
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_CLEAR);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign new_limit = ({21'd0, cfg_data} < 32'(VALUE_SLOTS)) ? cfg_data
                                                             : CNT_W'(VALUE_SLOTS);

  // source lookup: out-of-range indices count as unknown
  assign opa    = rd1[DATA_W-1:0];
  assign opb    = rd2[DATA_W-1:0];
  assign known1 = rd1[DATA_W] && ({1'b0, s1_r} < limit_r);
  assign known2 = rd2[DATA_W] && ({1'b0, s2_r} < limit_r);
  assign both   = known1 && known2;

  // table write: clearing sweep, or write-back of the destination
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(dst_r);
    mem_wdata = {fold_r, val_r};
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(clr_r);
      mem_wdata = '0;
    end else if (state_r == S_WB) begin
      mem_we = touch_r && dv_r && ({1'b0, dst_r} < limit_r);
    end
  end

  // unit launches from the execute cycle
  always_comb begin
    div_start = 1'b0;
    fpu_start = 1'b0;
    div_num   = opa;
    div_den   = opb;
    if ((state_r == S_EXEC) && both) begin
      if ((mode_r == MODE_INT) && ((op_r == OP_DIV) || (op_r == OP_MOD))) begin
        div_start = 1'b1;
      end
      if (mode_r == MODE_PDIFF) begin
        div_start = 1'b1;
        div_num   = opa - opb;
        div_den   = imm_r;
      end
      if ((mode_r == MODE_FLOAT) && (op_r <= FOP_MAX)) begin
        fpu_start = 1'b1;
      end
    end
  end

  cft_store #(
    .DEPTH (VALUE_SLOTS),
    .AW    (AW)
  ) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (in_acc),
    .raddr1 (AW'(in_tdata[20:11])),
    .raddr2 (AW'(in_tdata[30:21])),
    .rdata1 (rd1),
    .rdata2 (rd2)
  );

  cft_idiv u_idiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .rsp      (div_rsp)
  );

  cft_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fpu_start),
    .op    (op_r[1:0]),
    .a     (opa),
    .b     (opb),
    .rsp   (fpu_rsp)
  );

  // instruction latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_tuser[2:0];
      op_r   <= in_tuser[7:3];
      dv_r   <= in_tdata[0];
      dst_r  <= in_tdata[10:1];
      s1_r   <= in_tdata[20:11];
      s2_r   <= in_tdata[30:21];
      imm_r  <= in_tdata[62:31];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= '0;
      clr_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_acc) begin
            limit_r <= new_limit;
            clr_r   <= '0;
            state_r <= (new_limit != '0) ? S_CLEAR : S_IDLE;
          end else if (in_acc) begin
            touch_r <= 1'b1;
            state_r <= S_EXEC;
          end
        end
        S_CLEAR: begin
          if (cfg_acc) begin
            limit_r <= new_limit;
            clr_r   <= '0;
            state_r <= (new_limit != '0) ? S_CLEAR : S_IDLE;
          end else begin
            clr_r <= clr_r + CNT_W'(1);
            if (clr_r == limit_r - CNT_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_EXEC: begin
          fold_r     <= 1'b0;
          val_r      <= '0;
          wait_fp_r  <= (mode_r == MODE_FLOAT);
          want_rem_r <= (op_r == OP_MOD);
          state_r    <= S_WB;
          case (mode_r)
            MODE_CONST: begin
              fold_r <= 1'b1;
              val_r  <= imm_r;
            end
            MODE_INT: begin
              if (both) begin
                fold_r <= 1'b1;
                if (op_r == OP_MUL) begin
                  prod_r  <= opa * opb;
                  state_r <= S_MUL;
                end else if ((op_r == OP_DIV) || (op_r == OP_MOD)) begin
                  state_r <= S_WAIT;
                end else begin
                  val_r <= int_alu(op_r, opa, opb);
                end
              end
            end
            MODE_CAST: begin
              if (known1) begin
                fold_r <= 1'b1;
                val_r  <= opa;
              end
            end
            MODE_FLOAT: begin
              if (both) begin
                fold_r <= 1'b1;
                // codes beyond divide fold to zero
                if (op_r <= FOP_MAX) begin
                  state_r <= S_WAIT;
                end
              end
            end
            MODE_PADD: begin
              if (both) begin
                fold_r  <= 1'b1;
                prod_r  <= opb * imm_r;
                state_r <= S_MUL;
              end
            end
            MODE_PDIFF: begin
              if (both) begin
                fold_r  <= 1'b1;
                state_r <= S_WAIT;
              end
            end
            MODE_KILL: begin
              fold_r <= 1'b0;
            end
            default: begin
              touch_r <= 1'b0;
            end
          endcase
        end
        S_MUL: begin
          val_r   <= (mode_r == MODE_PADD) ? (opa + prod_r) : prod_r;
          state_r <= S_WB;
        end
        S_WAIT: begin
          if (wait_fp_r && fpu_rsp.done) begin
            val_r   <= fpu_rsp.value;
            state_r <= S_WB;
          end else if (!wait_fp_r && div_rsp.done) begin
            val_r   <= (want_rem_r && (mode_r == MODE_INT)) ? div_rsp.rem
                                                            : div_rsp.quot;
            state_r <= S_WB;
          end
        end
        S_WB: begin
          // table write repeats harmlessly while the output is blocked
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      if ((state_r == S_WB) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_WB) && out_free) begin
      out_tuser_r <= fold_r;
      out_tdata_r <= fold_r ? val_r : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // arithmetic units only report while the sequencer waits for them
  a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (div_rsp.done || fpu_rsp.done) |-> (state_r == S_WAIT))
    else $error("arithmetic unit finished outside wait state");

  // an unfolded result always carries a zero value
  a_unfolded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("unfolded result with non-zero value");

  // no table write in the cycle the source entries are read
  a_rw_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !mem_we)
    else $error("table write overlaps instruction read");

  // clearing pass blocks instructions
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> ((state_r == S_CLEAR) || (state_r == S_IDLE)))
    else $error("left clearing pass into execution");

endmodule

FILE: test/constant_fold_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_fold_tracker_test
// Self-checking bench for the constant folding tracker.
// ----------------------------------------------------------------------------
// Instructions go in as stream transactions. A local copy of the constant
// table predicts the folded flag and value of each one, and a checker
// compares every result transaction with the oldest prediction. The
// value_count register is rewritten between phases, each with its own idle
// and stall pattern. Float folding is predicted by widening to double,
// working in real and rounding back to binary32 by hand.
// ----------------------------------------------------------------------------
module constant_fold_tracker_test;
  import cft_pkg::*;

  localparam int SLOTS      = VALUE_SLOTS_DEF;
  localparam int WDOG_LIMIT = 8000;   // covers a full clearing pass plus slow float ops
  localparam int DRAIN_WAIT = 300;    // slowest instruction is well under this

  typedef struct packed {
    logic        folded;
    logic [31:0] value;
  } fold_res_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata   = '0;
  logic [7:0]        in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tuser;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data   = '0;

  // local copy of the tracker state
  logic        const_known [SLOTS];
  logic [31:0] const_value [SLOTS];
  int          slot_count;

  fold_res_t pending_folds[$];
  int        send_idle_pct;
  int        stall_pct;
  int        mismatches;
  int        quiet_cycles;

  constant_fold_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // arithmetic helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] signed_quot(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    if (b == 0) return 32'd0;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] signed_rem(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, r;
    if (b == 0) return 32'd0;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    r  = ma % mb;
    return a[31] ? -r : r;
  endfunction

  function automatic logic [31:0] int_fold(input logic [4:0] op, input logic [31:0] a,
                                           input logic [31:0] b);
    logic sa_lt_b, sb_lt_a;
    sa_lt_b = $signed(a) < $signed(b);
    sb_lt_a = $signed(b) < $signed(a);
    case (op)
      OP_ADD:  return a + b;
      OP_SUB:  return a - b;
      OP_MUL:  return a * b;
      OP_DIV:  return signed_quot(a, b);
      OP_MOD:  return signed_rem(a, b);
      OP_SHL:  return a << b[4:0];
      OP_SHR:  return $unsigned($signed(a) >>> b[4:0]);
      OP_AND:  return a & b;
      OP_OR:   return a | b;
      OP_XOR:  return a ^ b;
      OP_EQ:   return {31'd0, a == b};
      OP_NE:   return {31'd0, a != b};
      OP_LT:   return {31'd0, sa_lt_b};
      OP_GT:   return {31'd0, sb_lt_a};
      OP_LE:   return {31'd0, !sb_lt_a};
      OP_GE:   return {31'd0, !sa_lt_b};
      OP_LAND: return {31'd0, (a != 0) && (b != 0)};
      OP_LOR:  return {31'd0, (a != 0) || (b != 0)};
      default: return 32'd0;
    endcase
  endfunction

  // binary32 pattern -> real, exact
  function automatic real single_to_real(input logic [31:0] f);
    logic [63:0] d;
    logic [23:0] mm;
    int          ex;
    if (f[30:23] == 8'hFF)      d = {f[31], 11'h7FF, f[22:0], 29'd0};
    else if (f[30:0] == 0)      d = {f[31], 63'd0};
    else if (f[30:23] == 0) begin
      // subnormal: normalise into a double
      mm = {1'b0, f[22:0]};
      ex = -126;
      while (!mm[23]) begin
        mm = mm << 1;
        ex = ex - 1;
      end
      d = {f[31], 11'(ex + 1023), mm[22:0], 29'd0};
    end else                    d = {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0};
    return $bitstoreal(d);
  endfunction

  // real -> binary32 with round to nearest even, NaN made canonical
  function automatic logic [31:0] real_to_single(input real r);
    logic [63:0] d, sig, q, rest, half;
    int          fe, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 0) return {d[63], 31'd0};
    fe  = int'(d[62:52]) - 1023 + 127;
    sig = {11'd1, d[51:0]};
    sh  = (fe >= 1) ? 29 : 29 + 1 - fe;
    if (sh > 60) sh = 60;
    q    = sig >> sh;
    rest = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rest > half || (rest == half && q[0])) q = q + 1;
    if (fe < 1) return {d[63], q[30:0]};   // carry into 2^23 gives the least normal
    if (q[24]) begin
      q  = q >> 1;
      fe = fe + 1;
    end
    if (fe >= 255) return {d[63], 8'hFF, 23'd0};
    return {d[63], 8'(fe), q[22:0]};
  endfunction

  function automatic logic [31:0] float_fold(input logic [4:0] op, input logic [31:0] a,
                                             input logic [31:0] b);
    real ra, rb;
    ra = single_to_real(a);
    rb = single_to_real(b);
    case (op)
      5'(FOP_ADD): return real_to_single(ra + rb);
      5'(FOP_SUB): return real_to_single(ra - rb);
      5'(FOP_MUL): return real_to_single(ra * rb);
      5'(FOP_DIV): return (b[30:0] == 0) ? 32'd0 : real_to_single(ra / rb);
      default:     return 32'd0;
    endcase
  endfunction

  // predicts one instruction and updates the local table
  function automatic fold_res_t fold_instr(input logic [2:0] mode, input logic [4:0] op,
                                           input logic dv, input logic [9:0] d,
                                           input logic [9:0] s1, input logic [9:0] s2,
                                           input logic [31:0] imm);
    fold_res_t res;
    int          lim;
    logic        k1, k2, both, touch;
    logic [31:0] a, b;
    lim   = (slot_count < SLOTS) ? slot_count : SLOTS;
    k1    = (s1 < lim) && const_known[s1];
    k2    = (s2 < lim) && const_known[s2];
    both  = k1 && k2;
    a     = (s1 < lim) ? const_value[s1] : 32'd0;
    b     = (s2 < lim) ? const_value[s2] : 32'd0;
    res   = '0;
    touch = 1'b1;
    case (mode)
      MODE_CONST: res = '{1'b1, imm};
      MODE_INT:   if (both) res = '{1'b1, int_fold(op, a, b)};
      MODE_CAST:  if (k1) res = '{1'b1, a};
      MODE_FLOAT: if (both) res = '{1'b1, float_fold(op, a, b)};
      MODE_PADD:  if (both) res = '{1'b1, a + b * imm};
      MODE_PDIFF: if (both) res = '{1'b1, signed_quot(a - b, imm)};
      MODE_KILL:  ;
      default:    touch = 1'b0;
    endcase
    if (touch && dv && d < lim) begin
      const_known[d] = res.folded;
      if (res.folded) const_value[d] = res.value;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // driving
  // --------------------------------------------------------------------------
  task automatic send_instr(input logic [2:0] mode, input logic [4:0] op, input logic dv,
                            input logic [9:0] d, input logic [9:0] s1, input logic [9:0] s2,
                            input logic [31:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, imm, s2, s1, d, dv};
    in_tuser  <= {op, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_folds.push_back(fold_instr(mode, op, dv, d, s1, s2, imm));
  endtask

  // waits until the block is idle, then writes value_count
  task automatic write_count(input int count);
    in_tvalid <= 1'b0;
    while (pending_folds.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(count);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    slot_count = count;
    foreach (const_known[i]) const_known[i] = 1'b0;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    fold_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_folds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: folded=%0b value=%08h", out_tuser, out_tdata);
      end else begin
        want = pending_folds.pop_front();
        if (out_tuser !== want.folded || out_tdata !== want.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: folded exp %0b got %0b, value exp %08h got %08h",
                     want.folded, out_tuser, want.value, out_tdata);
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // value_count is 0 out of reset: nothing is ever known
  task automatic test_reset_state();
    send_instr(MODE_CONST, OP_ADD, 1'b1, 10'd0, 10'd0, 10'd0, 32'd5);
    send_instr(MODE_INT, OP_ADD, 1'b1, 10'd1, 10'd0, 10'd0, 32'd0);
    send_instr(MODE_CAST, OP_ADD, 1'b1, 10'd1, 10'd0, 10'd0, 32'd0);
  endtask

  // integer corner cases: INT_MIN / -1, divide by zero, full shifts
  task automatic test_int_corners();
    send_instr(MODE_CONST, OP_ADD, 1'b1, 10'd1, 10'd0, 10'd0, 32'h8000_0000);
    send_instr(MODE_CONST, OP_ADD, 1'b1, 10'd2, 10'd0, 10'd0, 32'hFFFF_FFFF);
    send_instr(MODE_CONST, OP_ADD, 1'b1, 10'd5, 10'd0, 10'd0, 32'd0);
    send_instr(MODE_CONST, OP_ADD, 1'b1, 10'd12, 10'd0, 10'd0, 32'h7FFF_FFFF);
    send_instr(MODE_INT, OP_DIV, 1'b1, 10'd3, 10'd1, 10'd2, 32'd0);
    send_instr(MODE_INT, OP_MOD, 1'b1, 10'd4, 10'd1, 10'd2, 32'd0);
    send_instr(MODE_INT, OP_DIV, 1'b1, 10'd6, 10'd1, 10'd5, 32'd0);
    send_instr(MODE_INT, OP_MOD, 1'b1, 10'd6, 10'd12, 10'd5, 32'd0);
    send_instr(MODE_INT, OP_SHL, 1'b1, 10'd7, 10'd2, 10'd2, 32'd0);
    send_instr(MODE_INT, OP_SHR, 1'b1, 10'd8, 10'd1, 10'd2, 32'd0);
    send_instr(MODE_INT, 5'd31, 1'b1, 10'd9, 10'd1, 10'd2, 32'd0);   // unknown op folds to 0
  endtask

  // float corners: inf - inf gives NaN, divide by zero gives +0
  task automatic test_float_corners();
    send_instr(MODE_CONST, OP_ADD, 1'b1, 10'd10, 10'd0, 10'd0, {1'b0, F_INF});
    send_instr(MODE_FLOAT, 5'(FOP_SUB), 1'b1, 10'd11, 10'd10, 10'd10, 32'd0);
    send_instr(MODE_FLOAT, 5'(FOP_DIV), 1'b1, 10'd11, 10'd10, 10'd5, 32'd0);
    send_instr(MODE_FLOAT, 5'd7, 1'b1, 10'd11, 10'd10, 10'd10, 32'd0);
  endtask

  // pointer arithmetic, cast, kill, pass, no destination, out of range
  task automatic test_misc_modes();
    send_instr(MODE_PADD, OP_ADD, 1'b1, 10'd13, 10'd12, 10'd2, 32'd4);
    send_instr(MODE_PDIFF, OP_ADD, 1'b1, 10'd14, 10'd1, 10'd12, 32'd0);
    send_instr(MODE_PDIFF, OP_ADD, 1'b1, 10'd14, 10'd1, 10'd5, 32'hFFFF_FFFF);
    send_instr(MODE_CAST, OP_ADD, 1'b1, 10'd15, 10'd12, 10'd9, 32'd0);
    send_instr(MODE_KILL, OP_ADD, 1'b1, 10'd12, 10'd0, 10'd0, 32'd0);
    send_instr(MODE_INT, OP_ADD, 1'b1, 10'd13, 10'd12, 10'd1, 32'd0);
    send_instr(MODE_PASS, OP_ADD, 1'b1, 10'd1, 10'd1, 10'd1, 32'd0);
    send_instr(MODE_CONST, OP_ADD, 1'b0, 10'd1, 10'd0, 10'd0, 32'd77);
    send_instr(MODE_INT, OP_ADD, 1'b1, 10'd3, 10'd20, 10'd1, 32'd0);
    send_instr(MODE_CONST, OP_ADD, 1'b1, 10'd500, 10'd0, 10'd0, 32'd9);
    send_instr(MODE_INT, OP_OR, 1'b1, 10'd3, 10'd1, 10'd1, 32'd0);
  endtask

  function automatic logic [9:0] pick_index(input int pool);
    if ($urandom_range(99) < 90) return 10'($urandom_range(pool - 1));
    return 10'($urandom_range(1023));
  endfunction

  function automatic logic [31:0] pick_constant();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'($signed($urandom_range(64)) - 32);
      6, 7:    return {1'($urandom), 8'($urandom_range(110, 144)), 23'($urandom)};
      8:       return {1'($urandom), ($urandom_range(1) ? 8'hFF : 8'h00), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // random instruction stream; constants feeding ops, indices mostly in a small pool
  task automatic test_random(input int count, input int n_items, input int idle,
                             input int stall);
    int          pool, r;
    logic [2:0]  mode;
    logic [4:0]  op;
    logic [31:0] imm;
    write_count(count);
    send_idle_pct = idle;
    stall_pct     = stall;
    pool = (count < SLOTS) ? count : SLOTS;
    if (pool > 24) pool = 24;
    if (pool < 1) pool = 1;
    repeat (n_items) begin
      r   = $urandom_range(99);
      op  = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(17));
      imm = pick_constant();
      if (r < 25) mode = MODE_CONST;
      else if (r < 55) mode = MODE_INT;
      else if (r < 60) mode = MODE_CAST;
      else if (r < 80) begin
        mode = MODE_FLOAT;
        if ($urandom_range(9) != 0) op = 5'($urandom_range(3));
      end else if (r < 85) mode = MODE_PADD;
      else if (r < 90) mode = MODE_PDIFF;
      else if (r < 95) mode = MODE_KILL;
      else mode = MODE_PASS;
      if ((mode == MODE_PADD || mode == MODE_PDIFF) && $urandom_range(3) != 0)
        imm = 32'($urandom_range(16));
      send_instr(mode, op, $urandom_range(9) != 0, pick_index(pool), pick_index(pool),
                 pick_index(pool), imm);
    end
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct     = 0;
    mismatches    = 0;
    slot_count    = 0;
    foreach (const_known[i]) begin
      const_known[i] = 1'b0;
      const_value[i] = 32'd0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    write_count(16);
    test_int_corners();
    test_float_corners();
    test_misc_modes();

    test_random(1024, 320, 0, 0);
    test_random(16, 320, 81, 0);
    test_random(2047, 320, 0, 81);
    test_random(1, 150, 11, 11);
    test_random(300, 320, 11, 11);
    test_random(1024, 320, 0, 0);
    test_random(0, 60, 0, 0);

    in_tvalid <= 1'b0;
    while (pending_folds.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
